// ===== rtl/rle2_pkg.sv =====
// ----------------------------------------------------------------------------
// rle2_pkg
// Shared types, codes and helper functions of the run-length v2 integer
// decoder.
// ----------------------------------------------------------------------------
package rle2_pkg;

  localparam int RUN_CAPACITY   = 512;
  localparam int MIN_REPEAT_LEN = 3;
  localparam int ADDR_W         = $clog2(RUN_CAPACITY);
  localparam int CNT_W          = 10;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RUN     = 3'd1;
  localparam logic [2:0] ST_BUSY    = 3'd2;
  localparam logic [2:0] ST_PATCHED = 3'd3;
  localparam logic [2:0] ST_WIDTH   = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  // Encoding field in the top two bits of a header byte.
  localparam logic [1:0] HM_SHORT   = 2'd0;
  localparam logic [1:0] HM_DIRECT  = 2'd1;
  localparam logic [1:0] HM_PATCHED = 2'd2;
  localparam logic [1:0] HM_DELTA   = 2'd3;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_SR,
    PH_DIR_LEN,
    PH_DIR_DATA,
    PH_DL_LEN,
    PH_DL_FIRST,
    PH_DL_STEP,
    PH_DL_BASE,
    PH_DL_DATA,
    PH_READY
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UNPACK,
    S_BASE2,
    S_RDATA,
    S_DONE
  } eng_t;

  function automatic logic [63:0] zigzag(input logic [63:0] u);
    zigzag = (u >> 1) ^ {64{u[0]}};
  endfunction

  function automatic logic [6:0] width_of(input logic [4:0] code);
    logic [6:0] w;
    case (code)
      5'd24:   w = 7'd26;
      5'd25:   w = 7'd28;
      5'd26:   w = 7'd30;
      5'd27:   w = 7'd32;
      5'd28:   w = 7'd40;
      5'd29:   w = 7'd48;
      5'd30:   w = 7'd56;
      5'd31:   w = 7'd64;
      default: w = 7'(code) + 7'd1;
    endcase
    width_of = w;
  endfunction

  function automatic logic width_ok(input logic [6:0] w);
    width_ok = (w == 7'd1) || (w == 7'd2) || (w == 7'd4) ||
               ((w >= 7'd8) && (w[2:0] == 3'd0));
  endfunction

endpackage

// ===== rtl/rle_v2_int_decoder_top.sv =====
// A pushed byte or a descriptor read goes from S_IDLE to S_DONE and its result
// is registered once the output is free; a literal store read passes S_RDATA,
// the byte that ends a packed delta base passes S_BASE2, and a packed data
// byte passes S_UNPACK, one value per cycle through the single write port
// of the literal store. One item is in work at a time.
// Reset (rst, synchronous) returns the parser to the header state; the
// literal store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// rle_v2_int_decoder_top
// Parses an RLE v2 integer byte stream into one run at a time and hands out
// the decoded values on read requests.
// ----------------------------------------------------------------------------
module rle_v2_int_decoder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [7:0]         byte_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [63:0] value,
  output logic               last_of_run,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               is_signed
);

  localparam int AW = rle2_pkg::ADDR_W;
  localparam int CW = rle2_pkg::CNT_W;

  rle2_pkg::eng_t   eng, eng_next;
  rle2_pkg::phase_t phase, phase_next;

  logic          sign_mode;
  logic [CW-1:0] run_count, run_count_next;
  logic [CW-1:0] read_index, read_index_next;
  logic [CW-1:0] fill_index, fill_index_next;
  logic [6:0]    hdr_width, hdr_width_next;
  logic          hdr_len_hi, hdr_len_hi_next;
  logic [8:0]    hdr_len, hdr_len_next;
  logic [3:0]    sr_left, sr_left_next;
  logic [63:0]   bit_acc, bit_acc_next;
  logic [3:0]    byte_cnt, byte_cnt_next;
  logic [7:0]    sh_byte, sh_byte_next;
  logic [3:0]    bits_left, bits_left_next;
  logic          wide_ready, wide_ready_next;
  logic [63:0]   vacc, vacc_next;
  logic [6:0]    vshift, vshift_next;
  logic [63:0]   run_base, run_base_next;
  logic [63:0]   run_step, run_step_next;
  logic          run_literal, run_literal_next;
  logic          delta_neg, delta_neg_next;
  logic [2:0]    pend_status, pend_status_next;
  logic [63:0]   pend_value, pend_value_next;
  logic          pend_last, pend_last_next;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [63:0]       mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [63:0]       mem_q;
  logic [63:0]       mem [rle2_pkg::RUN_CAPACITY];

  logic        accept;
  logic        out_free;
  logic [63:0] vterm;
  logic [63:0] vnew;
  logic        vdone;
  logic [63:0] sr_acc;
  logic [6:0]  dl_width;
  logic        narrow;
  logic        has_val;
  logic [63:0] raw;
  logic [63:0] wmask;
  logic [63:0] proc_val;
  logic [63:0] db;
  logic [3:0]  byte_cnt_inc;

  assign in_stall  = (eng != rle2_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // Varint byte folded into the accumulator; bits past bit 63 fall away.
  assign vterm = 64'(byte_in[6:0]) << vshift;
  assign vnew  = vacc | ((vshift < 7'd64) ? vterm : 64'd0);
  assign vdone = !byte_in[7];
  assign db    = rle2_pkg::zigzag(vnew);

  assign sr_acc   = {vacc[55:0], byte_in};
  assign dl_width = (byte_in[5:1] == 5'd0) ? 7'd0 : rle2_pkg::width_of(byte_in[5:1]);
  assign narrow   = (hdr_width <= 7'd8);
  assign byte_cnt_inc = byte_cnt + 4'd1;

  assign wmask = ~64'd0 >> (7'd64 - hdr_width);

  always_comb begin
    case (hdr_width[3:0])
      4'd1:    raw = 64'(sh_byte[7]);
      4'd2:    raw = 64'(sh_byte[7:6]);
      4'd4:    raw = 64'(sh_byte[7:4]);
      default: raw = 64'(sh_byte);
    endcase
    if (!narrow) begin
      raw = bit_acc & wmask;
    end
  end

  assign has_val = (narrow ? (bits_left >= hdr_width[3:0]) : wide_ready) &&
                   (fill_index < run_count);

  always_comb begin
    if (phase == rle2_pkg::PH_DIR_DATA) begin
      proc_val = sign_mode ? rle2_pkg::zigzag(raw) : raw;
    end else begin
      proc_val = delta_neg ? (run_base - raw) : (run_base + raw);
    end
  end

  always_comb begin
    eng_next         = eng;
    phase_next       = phase;
    run_count_next   = run_count;
    read_index_next  = read_index;
    fill_index_next  = fill_index;
    hdr_width_next   = hdr_width;
    hdr_len_hi_next  = hdr_len_hi;
    hdr_len_next     = hdr_len;
    sr_left_next     = sr_left;
    bit_acc_next     = bit_acc;
    byte_cnt_next    = byte_cnt;
    sh_byte_next     = sh_byte;
    bits_left_next   = bits_left;
    wide_ready_next  = wide_ready;
    vacc_next        = vacc;
    vshift_next      = vshift;
    run_base_next    = run_base;
    run_step_next    = run_step;
    run_literal_next = run_literal;
    delta_neg_next   = delta_neg;
    pend_status_next = pend_status;
    pend_value_next  = pend_value;
    pend_last_next   = pend_last;
    mem_we           = 1'b0;
    mem_waddr        = fill_index[AW-1:0];
    mem_wdata        = proc_val;
    mem_raddr        = read_index[AW-1:0];

    case (eng)
      rle2_pkg::S_IDLE: begin
        if (accept) begin
          pend_status_next = rle2_pkg::ST_OK;
          pend_value_next  = 64'd0;
          pend_last_next   = 1'b0;
          eng_next         = rle2_pkg::S_DONE;
          if (req_type) begin
            if (phase == rle2_pkg::PH_READY && read_index < run_count) begin
              if (run_literal) begin
                eng_next = rle2_pkg::S_RDATA;
              end else begin
                pend_value_next = run_base;
                run_base_next   = run_base + run_step;
              end
              read_index_next = read_index + 1'b1;
              if (read_index + 1'b1 >= run_count) begin
                pend_last_next = 1'b1;
                phase_next     = rle2_pkg::PH_HDR;
              end
            end else begin
              pend_status_next = rle2_pkg::ST_EMPTY;
            end
          end else begin
            case (phase)
              rle2_pkg::PH_READY: begin
                pend_status_next = rle2_pkg::ST_BUSY;
              end
              rle2_pkg::PH_HDR: begin
                case (byte_in[7:6])
                  rle2_pkg::HM_SHORT: begin
                    sr_left_next   = 4'(byte_in[5:3]) + 4'd1;
                    run_count_next = CW'(byte_in[2:0]) + CW'(rle2_pkg::MIN_REPEAT_LEN);
                    vacc_next      = 64'd0;
                    phase_next     = rle2_pkg::PH_SR;
                  end
                  rle2_pkg::HM_DIRECT: begin
                    hdr_width_next = rle2_pkg::width_of(byte_in[5:1]);
                    if (!rle2_pkg::width_ok(rle2_pkg::width_of(byte_in[5:1]))) begin
                      pend_status_next = rle2_pkg::ST_WIDTH;
                    end else begin
                      hdr_len_hi_next = byte_in[0];
                      phase_next      = rle2_pkg::PH_DIR_LEN;
                    end
                  end
                  rle2_pkg::HM_PATCHED: begin
                    pend_status_next = rle2_pkg::ST_PATCHED;
                  end
                  default: begin
                    hdr_width_next = dl_width;
                    if (dl_width != 7'd0 && !rle2_pkg::width_ok(dl_width)) begin
                      pend_status_next = rle2_pkg::ST_WIDTH;
                    end else begin
                      hdr_len_hi_next = byte_in[0];
                      phase_next      = rle2_pkg::PH_DL_LEN;
                    end
                  end
                endcase
              end
              rle2_pkg::PH_SR: begin
                vacc_next    = sr_acc;
                sr_left_next = sr_left - 4'd1;
                if (sr_left == 4'd1) begin
                  run_base_next    = sign_mode ? rle2_pkg::zigzag(sr_acc) : sr_acc;
                  run_step_next    = 64'd0;
                  run_literal_next = 1'b0;
                  read_index_next  = '0;
                  phase_next       = rle2_pkg::PH_READY;
                  pend_status_next = rle2_pkg::ST_RUN;
                end
              end
              rle2_pkg::PH_DIR_LEN: begin
                run_count_next  = CW'({hdr_len_hi, byte_in}) + CW'(1);
                fill_index_next = '0;
                bit_acc_next    = 64'd0;
                byte_cnt_next   = 4'd0;
                wide_ready_next = 1'b0;
                phase_next      = rle2_pkg::PH_DIR_DATA;
              end
              rle2_pkg::PH_DIR_DATA, rle2_pkg::PH_DL_DATA: begin
                eng_next = rle2_pkg::S_UNPACK;
                if (narrow) begin
                  sh_byte_next   = byte_in;
                  bits_left_next = 4'd8;
                end else begin
                  bit_acc_next = {bit_acc[55:0], byte_in};
                  if (byte_cnt_inc == hdr_width[6:3]) begin
                    wide_ready_next = 1'b1;
                    byte_cnt_next   = 4'd0;
                  end else begin
                    byte_cnt_next = byte_cnt_inc;
                  end
                end
              end
              rle2_pkg::PH_DL_LEN: begin
                hdr_len_next = {hdr_len_hi, byte_in};
                vacc_next    = 64'd0;
                vshift_next  = 7'd0;
                phase_next   = rle2_pkg::PH_DL_FIRST;
              end
              rle2_pkg::PH_DL_FIRST, rle2_pkg::PH_DL_STEP, rle2_pkg::PH_DL_BASE: begin
                vacc_next = vnew;
                if (vshift < 7'd64) begin
                  vshift_next = vshift + 7'd7;
                end
                if (vdone) begin
                  vacc_next   = 64'd0;
                  vshift_next = 7'd0;
                  if (phase == rle2_pkg::PH_DL_FIRST) begin
                    run_base_next = sign_mode ? db : vnew;
                    phase_next    = (hdr_width == 7'd0) ? rle2_pkg::PH_DL_STEP
                                                        : rle2_pkg::PH_DL_BASE;
                  end else if (phase == rle2_pkg::PH_DL_STEP) begin
                    run_step_next    = db;
                    run_count_next   = CW'(hdr_len) + CW'(1);
                    run_literal_next = 1'b0;
                    read_index_next  = '0;
                    phase_next       = rle2_pkg::PH_READY;
                    pend_status_next = rle2_pkg::ST_RUN;
                  end else begin
                    // First stored value is the base; the second follows in S_BASE2.
                    run_step_next    = db;
                    delta_neg_next   = db[63];
                    mem_we           = 1'b1;
                    mem_waddr        = '0;
                    mem_wdata        = run_base;
                    run_count_next   = (hdr_len == 9'd0) ? CW'(2) : CW'(hdr_len) + CW'(1);
                    run_literal_next = 1'b1;
                    eng_next         = rle2_pkg::S_BASE2;
                  end
                end
              end
              default: begin
                phase_next = rle2_pkg::PH_HDR;
              end
            endcase
          end
        end
      end
      rle2_pkg::S_BASE2: begin
        mem_we          = 1'b1;
        mem_waddr       = AW'(1);
        mem_wdata       = run_base + run_step;
        run_base_next   = run_base + run_step;
        fill_index_next = CW'(2);
        bit_acc_next    = 64'd0;
        byte_cnt_next   = 4'd0;
        wide_ready_next = 1'b0;
        if (run_count > CW'(2)) begin
          phase_next = rle2_pkg::PH_DL_DATA;
        end else begin
          read_index_next  = '0;
          phase_next       = rle2_pkg::PH_READY;
          pend_status_next = rle2_pkg::ST_RUN;
        end
        eng_next = rle2_pkg::S_DONE;
      end
      rle2_pkg::S_UNPACK: begin
        if (has_val) begin
          mem_we          = 1'b1;
          fill_index_next = fill_index + 1'b1;
          if (phase == rle2_pkg::PH_DL_DATA) begin
            run_base_next = proc_val;
          end
          if (narrow) begin
            sh_byte_next   = sh_byte << hdr_width[3:0];
            bits_left_next = bits_left - hdr_width[3:0];
          end else begin
            wide_ready_next = 1'b0;
          end
        end else begin
          // Bits left over in the last byte of a run are dropped here.
          if (fill_index >= run_count) begin
            run_literal_next = 1'b1;
            read_index_next  = '0;
            phase_next       = rle2_pkg::PH_READY;
            pend_status_next = rle2_pkg::ST_RUN;
          end
          eng_next = rle2_pkg::S_DONE;
        end
      end
      rle2_pkg::S_RDATA: begin
        pend_value_next = mem_q;
        eng_next        = rle2_pkg::S_DONE;
      end
      rle2_pkg::S_DONE: begin
        if (out_free) begin
          eng_next = rle2_pkg::S_IDLE;
        end
      end
      default: begin
        eng_next = rle2_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eng         <= rle2_pkg::S_IDLE;
      phase       <= rle2_pkg::PH_HDR;
      sign_mode   <= 1'b0;
      run_count   <= '0;
      read_index  <= '0;
      fill_index  <= '0;
      hdr_width   <= 7'd0;
      hdr_len_hi  <= 1'b0;
      hdr_len     <= 9'd0;
      sr_left     <= 4'd0;
      bit_acc     <= 64'd0;
      byte_cnt    <= 4'd0;
      sh_byte     <= 8'd0;
      bits_left   <= 4'd0;
      wide_ready  <= 1'b0;
      vacc        <= 64'd0;
      vshift      <= 7'd0;
      run_base    <= 64'd0;
      run_step    <= 64'd0;
      run_literal <= 1'b0;
      delta_neg   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      eng         <= eng_next;
      phase       <= phase_next;
      run_count   <= run_count_next;
      read_index  <= read_index_next;
      fill_index  <= fill_index_next;
      hdr_width   <= hdr_width_next;
      hdr_len_hi  <= hdr_len_hi_next;
      hdr_len     <= hdr_len_next;
      sr_left     <= sr_left_next;
      bit_acc     <= bit_acc_next;
      byte_cnt    <= byte_cnt_next;
      sh_byte     <= sh_byte_next;
      bits_left   <= bits_left_next;
      wide_ready  <= wide_ready_next;
      vacc        <= vacc_next;
      vshift      <= vshift_next;
      run_base    <= run_base_next;
      run_step    <= run_step_next;
      run_literal <= run_literal_next;
      delta_neg   <= delta_neg_next;
      if (cfg_valid && cfg_ready) begin
        sign_mode <= is_signed;
      end
      if (eng == rle2_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_status <= pend_status_next;
    pend_value  <= pend_value_next;
    pend_last   <= pend_last_next;
    if (eng == rle2_pkg::S_DONE && out_free) begin
      status      <= pend_status;
      value       <= pend_value;
      last_of_run <= pend_last;
    end
  end

  // A literal read takes its data in the cycle after the address is issued.
  a_rdata_after_idle: assert property (@(posedge clk) disable iff (rst)
    eng == rle2_pkg::S_RDATA |-> $past(eng) == rle2_pkg::S_IDLE)
    else $error("literal read data stage not entered from idle");

  a_ready_index: assert property (@(posedge clk) disable iff (rst)
    phase == rle2_pkg::PH_READY |-> read_index < run_count)
    else $error("ready run has no value left");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (mem_we && eng == rle2_pkg::S_UNPACK) |-> fill_index < run_count)
    else $error("literal store write beyond the run");

  a_done_exit: assert property (@(posedge clk) disable iff (rst)
    eng == rle2_pkg::S_DONE |=> eng == rle2_pkg::S_DONE || eng == rle2_pkg::S_IDLE)
    else $error("result stage left to a work state");

endmodule

// ===== verif/rle_v2_int_decoder_top_test.sv =====
// ----------------------------------------------------------------------------
// rle_v2_int_decoder_top_test
// Drives byte pushes and value reads into the run-length v2 integer decoder,
// predicts every result with a behavioral model of the stream parser and
// checks status, value and end-of-run flag in order. Random idling on both
// sides, one long receiver hold-off and drain pauses are included.
// ----------------------------------------------------------------------------
module rle_v2_int_decoder_top_test;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [63:0] val;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic       has_exp;
    logic [2:0] exp_st;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic [7:0] byte_in;
  logic out_valid;
  logic out_stall;
  logic [2:0] status;
  logic signed [63:0] value;
  logic last_of_run;
  logic cfg_valid;
  logic cfg_ready;
  logic is_signed;

  rle_v2_int_decoder_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .byte_in(byte_in), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .value(value),
    .last_of_run(last_of_run), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .is_signed(is_signed)
  );

  // Predictor state.
  logic [63:0] m_store [0:rle2_pkg::RUN_CAPACITY-1];
  int unsigned m_count, m_rd, m_fill, m_width, m_len_hi, m_len, m_sr_left;
  int unsigned m_bits, m_vshift;
  rle2_pkg::phase_t m_phase;
  logic        m_signed;
  logic [63:0] m_acc, m_vacc, m_base, m_step;
  logic        m_literal, m_neg;

  result_t expected_q[$];
  int      n_fail;
  int      n_mismatch;
  int      n_sent;
  longint  cycle;
  bit      hold_long;
  bit      timed_out;

  localparam int LIMIT = 400000;

  function automatic logic [63:0] unzig(input logic [63:0] u);
    return (u >> 1) ^ (64'd0 - {63'd0, u[0]});
  endfunction

  function automatic int unsigned map_width(input logic [4:0] c);
    int unsigned hi[8] = '{26, 28, 30, 32, 40, 48, 56, 64};
    if (c < 24) return c + 1;
    return hi[c - 24];
  endfunction

  function automatic bit width_good(input int unsigned w);
    return w == 1 || w == 2 || w == 4 || (w >= 8 && w <= 64 && w % 8 == 0);
  endfunction

  function automatic bit take_varint(input logic [7:0] b);
    if (m_vshift < 64) begin
      m_vacc = m_vacc | ({57'd0, b[6:0]} << m_vshift);
      m_vshift += 7;
    end
    return !b[7];
  endfunction

  function automatic void store_value(input logic [63:0] v);
    if (m_fill < rle2_pkg::RUN_CAPACITY) m_store[m_fill] = v;
    m_fill++;
  endfunction

  // Shifts a packed byte in; true once the run's last value is stored.
  function automatic bit unpack_packed(input logic [7:0] b);
    logic [63:0] mask, v;
    mask = m_width >= 64 ? '1 : ((64'd1 << m_width) - 1);
    m_acc = (m_acc << 8) | {56'd0, b};
    m_bits += 8;
    while (m_bits >= m_width && m_fill < m_count) begin
      v = (m_acc >> (m_bits - m_width)) & mask;
      m_bits -= m_width;
      if (m_phase == rle2_pkg::PH_DIR_DATA) begin
        if (m_signed) v = unzig(v);
      end else begin
        v = m_neg ? m_base - v : m_base + v;
        m_base = v;
      end
      store_value(v);
    end
    return m_fill >= m_count;
  endfunction

  function automatic logic [2:0] decode_byte(input logic [7:0] b);
    logic [4:0]  code;
    logic [63:0] db;
    case (m_phase)
      rle2_pkg::PH_HDR: begin
        case (b[7:6])
          rle2_pkg::HM_SHORT: begin
            m_sr_left = b[5:3] + 1;
            m_count = b[2:0] + rle2_pkg::MIN_REPEAT_LEN;
            m_vacc = 0;
            m_phase = rle2_pkg::PH_SR;
            return rle2_pkg::ST_OK;
          end
          rle2_pkg::HM_DIRECT: begin
            m_width = map_width(b[5:1]);
            if (!width_good(m_width)) return rle2_pkg::ST_WIDTH;
            m_len_hi = b[0];
            m_phase = rle2_pkg::PH_DIR_LEN;
            return rle2_pkg::ST_OK;
          end
          rle2_pkg::HM_PATCHED: return rle2_pkg::ST_PATCHED;
          default: begin
            code = b[5:1];
            m_width = code != 0 ? map_width(code) : 0;
            if (m_width != 0 && !width_good(m_width)) return rle2_pkg::ST_WIDTH;
            m_len_hi = b[0];
            m_phase = rle2_pkg::PH_DL_LEN;
            return rle2_pkg::ST_OK;
          end
        endcase
      end
      rle2_pkg::PH_SR: begin
        m_vacc = (m_vacc << 8) | {56'd0, b};
        m_sr_left--;
        if (m_sr_left != 0) return rle2_pkg::ST_OK;
        m_base = m_signed ? unzig(m_vacc) : m_vacc;
        m_step = 0;
        m_literal = 0;
      end
      rle2_pkg::PH_DIR_LEN: begin
        m_count = ((m_len_hi << 8) | b) + 1;
        m_fill = 0;
        m_acc = 0;
        m_bits = 0;
        m_phase = rle2_pkg::PH_DIR_DATA;
        return rle2_pkg::ST_OK;
      end
      rle2_pkg::PH_DIR_DATA: begin
        if (!unpack_packed(b)) return rle2_pkg::ST_OK;
        m_literal = 1;
      end
      rle2_pkg::PH_DL_LEN: begin
        m_len = (m_len_hi << 8) | b;
        m_vacc = 0;
        m_vshift = 0;
        m_phase = rle2_pkg::PH_DL_FIRST;
        return rle2_pkg::ST_OK;
      end
      rle2_pkg::PH_DL_FIRST: begin
        if (!take_varint(b)) return rle2_pkg::ST_OK;
        m_base = m_signed ? unzig(m_vacc) : m_vacc;
        m_vacc = 0;
        m_vshift = 0;
        m_phase = m_width == 0 ? rle2_pkg::PH_DL_STEP : rle2_pkg::PH_DL_BASE;
        return rle2_pkg::ST_OK;
      end
      rle2_pkg::PH_DL_STEP: begin
        if (!take_varint(b)) return rle2_pkg::ST_OK;
        m_step = unzig(m_vacc);
        m_count = m_len + 1;
        m_literal = 0;
      end
      rle2_pkg::PH_DL_BASE: begin
        if (!take_varint(b)) return rle2_pkg::ST_OK;
        db = unzig(m_vacc);
        m_neg = db[63];
        m_fill = 0;
        store_value(m_base);
        m_base += db;
        store_value(m_base);
        m_count = 2 + (m_len != 0 ? m_len - 1 : 0);
        m_acc = 0;
        m_bits = 0;
        m_literal = 1;
        if (m_fill < m_count) begin
          m_phase = rle2_pkg::PH_DL_DATA;
          return rle2_pkg::ST_OK;
        end
      end
      rle2_pkg::PH_DL_DATA: begin
        if (!unpack_packed(b)) return rle2_pkg::ST_OK;
      end
      default: begin
        m_phase = rle2_pkg::PH_HDR;
        return rle2_pkg::ST_OK;
      end
    endcase
    m_rd = 0;
    m_phase = rle2_pkg::PH_READY;
    return rle2_pkg::ST_RUN;
  endfunction

  function automatic result_t decode_item(input item_t it);
    result_t r;
    r = '0;
    if (!it.req) begin
      r.st = m_phase == rle2_pkg::PH_READY ? rle2_pkg::ST_BUSY : decode_byte(it.data);
    end else if (m_phase == rle2_pkg::PH_READY && m_rd < m_count) begin
      if (m_literal) begin
        r.val = m_rd < rle2_pkg::RUN_CAPACITY ? m_store[m_rd] : 64'd0;
      end else begin
        r.val = m_base;
        m_base += m_step;
      end
      m_rd++;
      if (m_rd >= m_count) begin
        r.last = 1;
        m_phase = rle2_pkg::PH_HDR;
      end
    end else begin
      r.st = rle2_pkg::ST_EMPTY;
    end
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle = 0;
    timed_out = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle > LIMIT && !timed_out) begin
        timed_out = 1;
        $display("rle_v2_int_decoder_top verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and the result checker.
  initial begin
    int unsigned wait_n;
    result_t exp_r;
    out_stall = 1'b0;
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_mismatch++ < 10) $display("unexpected result status=%0d", status);
      end else begin
        exp_r = expected_q.pop_front();
        if (status !== exp_r.st || value !== exp_r.val || last_of_run !== exp_r.last) begin
          n_fail++;
          if (n_mismatch++ < 10)
            $display("mismatch: exp st=%0d val=%h last=%0d got st=%0d val=%h last=%0d",
                     exp_r.st, exp_r.val, exp_r.last, status, value, last_of_run);
        end
      end
    end
  end

  // Sends one item, waiting out a random gap first.
  task automatic send_item(input item_t it, input int unsigned gap, input bit chk,
                           input logic [2:0] st);
    result_t r;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.req;
    byte_in  <= it.data;
    do @(posedge clk); while (in_stall);
    r = decode_item(it);
    if (chk && r.st !== st) begin
      n_fail++;
      if (n_mismatch++ < 10) $display("table row: predicted %0d, typed %0d", r.st, st);
    end
    expected_q.push_back(r);
    n_sent++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    send_item('{req: 1'b0, data: b}, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8),
              1'b0, rle2_pkg::ST_OK);
  endtask

  task automatic read_value();
    send_item('{req: 1'b1, data: 8'($urandom)}, $urandom_range(0, 8), 1'b0,
              rle2_pkg::ST_OK);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_sign(input logic s);
    cfg_valid <= 1'b1;
    is_signed <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_signed = s;
  endtask

  task automatic push_varint();
    int unsigned n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++)
      push_byte({i != n - 1 ? 1'b1 : 1'b0, 7'($urandom)});
  endtask

  // One well-formed run with random content, then reads that drain it.
  task automatic random_run();
    int unsigned kind, code, w, len;
    logic [4:0] wc[11] = '{0, 1, 3, 7, 15, 23, 27, 28, 29, 30, 31};
    kind = $urandom_range(0, 2);
    code = wc[$urandom_range(0, 10)];
    w = map_width(code);
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    if (kind == 0) begin
      push_byte({2'b00, 3'($urandom), 3'($urandom)});
      for (int i = 0; i < 8 && m_phase == rle2_pkg::PH_SR; i++) push_byte(8'($urandom));
    end else if (kind == 1) begin
      push_byte({2'b01, 5'(code), len[8]});
      push_byte(len[7:0]);
      for (int i = 0; i < ((len + 1) * w + 7) / 8; i++) push_byte(8'($urandom));
    end else begin
      code = $urandom_range(0, 2) == 0 ? 0 : code;
      push_byte({2'b11, 5'(code), len[8]});
      push_byte(len[7:0]);
      push_varint();
      push_varint();
      while (m_phase == rle2_pkg::PH_DL_DATA) push_byte(8'($urandom));
    end
    while (m_phase == rle2_pkg::PH_READY) read_value();
  endtask

  row_t dir_rows[$];

  initial begin
    int unsigned pick;
    logic lone_req;
    row_t r;
    n_fail = 0;
    n_mismatch = 0;
    n_sent = 0;
    hold_long = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = 1'b0;
    byte_in = 8'd0;
    cfg_valid = 1'b0;
    is_signed = 1'b0;
    m_phase = rle2_pkg::PH_HDR;
    m_signed = 0;
    {m_count, m_rd, m_fill, m_width, m_len_hi, m_len, m_sr_left, m_bits, m_vshift} = '0;
    {m_acc, m_vacc, m_base, m_step, m_literal, m_neg} = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_sign(1'b1);
    // Directed rows: empty read, patched header, bad widths, short repeat of
    // all-ones, busy push, reads that drain it, delta of length zero, fixed
    // step delta.
    dir_rows = '{
      '{1'b1, 8'h00, 1'b1, rle2_pkg::ST_EMPTY},
      '{1'b0, 8'h80, 1'b1, rle2_pkg::ST_PATCHED},
      '{1'b0, 8'h44, 1'b1, rle2_pkg::ST_WIDTH},
      '{1'b0, 8'hC4, 1'b1, rle2_pkg::ST_WIDTH},
      '{1'b0, 8'h3F, 1'b1, rle2_pkg::ST_OK},
      '{1'b0, 8'hFF, 1'b0, rle2_pkg::ST_OK}, '{1'b0, 8'hFF, 1'b0, rle2_pkg::ST_OK},
      '{1'b0, 8'hFF, 1'b0, rle2_pkg::ST_OK}, '{1'b0, 8'hFF, 1'b0, rle2_pkg::ST_OK},
      '{1'b0, 8'hFF, 1'b0, rle2_pkg::ST_OK}, '{1'b0, 8'hFF, 1'b0, rle2_pkg::ST_OK},
      '{1'b0, 8'hFF, 1'b0, rle2_pkg::ST_OK}, '{1'b0, 8'hFF, 1'b1, rle2_pkg::ST_RUN},
      '{1'b0, 8'h00, 1'b1, rle2_pkg::ST_BUSY},
      '{1'b1, 8'h00, 1'b1, rle2_pkg::ST_OK}, '{1'b1, 8'h00, 1'b0, rle2_pkg::ST_OK},
      '{1'b1, 8'h00, 1'b0, rle2_pkg::ST_OK}, '{1'b1, 8'h00, 1'b0, rle2_pkg::ST_OK},
      '{1'b1, 8'h00, 1'b0, rle2_pkg::ST_OK}, '{1'b1, 8'h00, 1'b0, rle2_pkg::ST_OK},
      '{1'b1, 8'h00, 1'b0, rle2_pkg::ST_OK}, '{1'b1, 8'h00, 1'b0, rle2_pkg::ST_OK},
      '{1'b1, 8'h00, 1'b0, rle2_pkg::ST_OK}, '{1'b1, 8'h00, 1'b0, rle2_pkg::ST_OK},
      '{1'b0, 8'hC2, 1'b1, rle2_pkg::ST_OK}, '{1'b0, 8'h00, 1'b1, rle2_pkg::ST_OK},
      '{1'b0, 8'h81, 1'b1, rle2_pkg::ST_OK}, '{1'b0, 8'h01, 1'b1, rle2_pkg::ST_OK},
      '{1'b0, 8'h03, 1'b1, rle2_pkg::ST_RUN},
      '{1'b1, 8'h00, 1'b1, rle2_pkg::ST_OK}, '{1'b1, 8'h00, 1'b1, rle2_pkg::ST_OK},
      '{1'b1, 8'h00, 1'b1, rle2_pkg::ST_EMPTY},
      '{1'b0, 8'hC0, 1'b1, rle2_pkg::ST_OK}, '{1'b0, 8'h02, 1'b1, rle2_pkg::ST_OK},
      '{1'b0, 8'h05, 1'b1, rle2_pkg::ST_OK}, '{1'b0, 8'h04, 1'b1, rle2_pkg::ST_RUN}
    };
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_item('{req: r.req, data: r.data}, $urandom_range(0, 2), r.has_exp, r.exp_st);
    end
    while (m_phase == rle2_pkg::PH_READY) read_value();
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      write_sign(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom));
      if (ph == 2) hold_long = 1;
      while (n_sent < 126 * (ph + 1) + 40) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          random_run();
        end else begin
          // A lone read, or a patched header that leaves the parser in place.
          lone_req = 1'($urandom);
          send_item('{req: lone_req, data: lone_req ? 8'($urandom) : {2'b10, 6'($urandom)}},
                    $urandom_range(0, 8), 1'b0, rle2_pkg::ST_OK);
        end
      end
      while (m_phase == rle2_pkg::PH_READY) read_value();
      // Finish any half-parsed run so the register write sees an idle block.
      while (m_phase != rle2_pkg::PH_HDR) begin
        push_byte(8'($urandom));
        while (m_phase == rle2_pkg::PH_READY) read_value();
      end
      drain_all();
    end

    if (n_fail == 0) begin
      $display("rle_v2_int_decoder_top verification clean");
    end else begin
      $display("rle_v2_int_decoder_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rle2_pkg.sv
rtl/rle_v2_int_decoder_top.sv
verif/rle_v2_int_decoder_top_test.sv
